@@ design/lhd_pkg.sv @@
// shared types and constants of the linear hash duplicate filter
`default_nettype none
package lhd_pkg;

  localparam int unsigned DATA_W      = 32;
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QA_W        = $clog2(QUEUE_DEPTH);
  localparam int unsigned QC_W        = $clog2(QUEUE_DEPTH + 1);

  // one result item handed from the engine to the output register
  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic                     is_new;
    logic                     table_full;
  } lhd_res_t;

endpackage
`default_nettype wire

@@ design/lhd_front.sv @@
// front queue: accepts items and holds them until the engine takes them
`default_nettype none
module lhd_front (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic signed [lhd_pkg::DATA_W-1:0]   in_value,
  output logic                                     q_valid,
  input  wire logic                                q_ready,
  output logic signed [lhd_pkg::DATA_W-1:0]        q_value
);

  logic signed [lhd_pkg::DATA_W-1:0] mem_r [lhd_pkg::QUEUE_DEPTH];
  logic [lhd_pkg::QA_W-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [lhd_pkg::QC_W-1:0] cnt_r, cnt_nxt;
  logic push, pop;

  assign in_ready = (cnt_r != lhd_pkg::QC_W'(lhd_pkg::QUEUE_DEPTH));
  assign q_valid  = (cnt_r != '0);
  assign q_value  = mem_r[rp_r];
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wp_nxt = (wp_r == lhd_pkg::QA_W'(lhd_pkg::QUEUE_DEPTH - 1)) ? '0 : wp_r + 1'b1;
    end
    if (pop) begin
      rp_nxt = (rp_r == lhd_pkg::QA_W'(lhd_pkg::QUEUE_DEPTH - 1)) ? '0 : rp_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= in_value;
    end
  end

endmodule
`default_nettype wire

@@ design/lhd_engine.sv @@
// back end: chain search, insert and bucket split sequencer with its memories
`default_nettype none
module lhd_engine #(
  parameter int unsigned PAGE_CAPACITY = 30,
  parameter int unsigned MAX_BUCKETS   = 64,
  parameter int unsigned MAX_PAGES     = 128
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                q_valid,
  output logic                                     q_ready,
  input  wire logic signed [lhd_pkg::DATA_W-1:0]   q_value,
  output logic                                     res_valid,
  input  wire logic                                res_ready,
  output lhd_pkg::lhd_res_t                        res
);

  localparam int unsigned STORE  = MAX_PAGES * PAGE_CAPACITY;
  localparam int unsigned PG_W   = $clog2(MAX_PAGES);
  localparam int unsigned FC_W   = $clog2(MAX_PAGES + 1);
  localparam int unsigned PC_W   = FC_W + 1;
  localparam int unsigned BK_W   = $clog2(MAX_BUCKETS);
  localparam int unsigned BC_W   = $clog2(MAX_BUCKETS + 1);
  localparam int unsigned MOD_W  = BK_W + 1;
  localparam int unsigned FILL_W = $clog2(PAGE_CAPACITY + 1);
  localparam int unsigned SLOT_W = $clog2(PAGE_CAPACITY);
  localparam int unsigned SA_W   = $clog2(STORE);
  localparam int unsigned CNT_W  = $clog2(STORE + 1);
  localparam int unsigned LD_W   = CNT_W + BC_W + FILL_W + 4;
  localparam int unsigned DW     = lhd_pkg::DATA_W;

  typedef enum logic [20:0] {
    S_IDLE  = 21'h000001, S_HASH  = 21'h000002, S_HRD   = 21'h000004,
    S_HEAD  = 21'h000008, S_PGRD  = 21'h000010, S_PAGE  = 21'h000020,
    S_ERD   = 21'h000040, S_ECMP  = 21'h000080, S_EOP   = 21'h000100,
    S_TWT   = 21'h000200, S_TAIL  = 21'h000400, S_RES   = 21'h000800,
    S_CHK   = 21'h001000, S_DEC   = 21'h002000, S_FWT   = 21'h004000,
    S_FPUSH = 21'h008000, S_BW    = 21'h010000, S_BT    = 21'h020000,
    S_SRD   = 21'h040000, S_SCHK  = 21'h080000, S_FIN   = 21'h100000
  } state_t;

  function automatic logic [BK_W-1:0] bkt_of(input logic [DW-1:0] v,
                                             input logic [MOD_W-1:0] cnt,
                                             input logic [MOD_W-1:0] md);
    logic [MOD_W-1:0] idx;
    idx = v[MOD_W-1:0] & (md - MOD_W'(1));
    if (idx >= cnt) begin
      idx = idx - (md >> 1);
    end
    if (idx >= cnt || idx >= MOD_W'(MAX_BUCKETS)) begin
      idx = '0;
    end
    return idx[BK_W-1:0];
  endfunction

  // control and bookkeeping registers
  state_t              state_r, state_nxt;
  logic [DW-1:0]       val_r, val_nxt;
  logic [BK_W-1:0]     b_r, b_nxt, sp_r, sp_nxt;
  logic [PG_W-1:0]     page_r, page_nxt, tail_r, tail_nxt, head_r, head_nxt;
  logic [PG_W-1:0]     cur_r, cur_nxt;
  logic [FILL_W-1:0]   fill_r, fill_nxt, cfill_r, cfill_nxt;
  logic [FILL_W-1:0]   sslot_r, sslot_nxt, mslot_r, mslot_nxt;
  logic [SLOT_W-1:0]   slot_r, slot_nxt;
  logic                gath_r, gath_nxt, grp_r, grp_nxt;
  logic                rnew_r, rnew_nxt, rfull_r, rfull_nxt;
  logic [BC_W-1:0]     bc_r, bc_nxt;
  logic [MOD_W-1:0]    hm_r, hm_nxt, smod_r, smod_nxt;
  logic [CNT_W-1:0]    et_r, et_nxt, n_r, n_nxt, idx_r, idx_nxt;
  logic [FC_W-1:0]     fc_r, fc_nxt, oldp_r, oldp_nxt;
  logic [FC_W-1:0]     fcmin_r;
  logic [PC_W-1:0]     spg_r, spg_nxt, mpg_r, mpg_nxt;

  // memories
  logic [DW-1:0]       ent_mem [STORE];
  logic [DW:0]         spl_mem [STORE];
  logic [FILL_W-1:0]   fill_mem [MAX_PAGES];
  logic [PG_W-1:0]     link_mem [MAX_PAGES];
  logic [PG_W-1:0]     head_mem [MAX_BUCKETS];
  logic [PG_W-1:0]     tail_mem [MAX_BUCKETS];
  logic [PG_W-1:0]     fs_mem [MAX_PAGES];
  logic [MAX_PAGES-1:0]   fill_vld_r, linkv_r;
  logic [MAX_BUCKETS-1:0] head_vld_r, tail_vld_r;

  logic [DW-1:0]       ent_q;
  logic [DW:0]         spl_q;
  logic [FILL_W-1:0]   fill_q;
  logic [PG_W-1:0]     link_q, head_q, tail_q, fs_q;
  logic [PG_W-1:0]     fs_ra;

  // write controls
  logic                ent_we, spl_we, fill_we, link_we, head_we, tail_we, fs_we;
  logic                lvs_en, lvc_en;
  logic [PG_W-1:0]     ent_wpg, fill_wa, link_wa, link_wd, tail_wd, head_wd;
  logic [PG_W-1:0]     lvs_a, lvc_a;
  logic [FILL_W-1:0]   ent_wslot, fill_wd;
  logic [DW-1:0]       ent_wd;
  logic [DW:0]         spl_wd;
  logic [SA_W-1:0]     ent_wa, ent_ra;

  logic                mv;
  logic [LD_W-1:0]     load_lhs, load_rhs;
  logic [MOD_W-1:0]    nb_m;

  assign fs_ra    = fc_r[PG_W-1:0] - PG_W'(1);
  assign ent_ra   = SA_W'(page_r) * SA_W'(PAGE_CAPACITY) + SA_W'(slot_r);
  assign ent_wa   = SA_W'(ent_wpg) * SA_W'(PAGE_CAPACITY) + SA_W'(ent_wslot);
  assign nb_m     = MOD_W'(bc_r) + MOD_W'(1);
  assign mv       = (MOD_W'(bkt_of(ent_q, nb_m, smod_r)) == MOD_W'(bc_r));
  assign load_lhs = LD_W'(et_r) * LD_W'(4);
  assign load_rhs = LD_W'(bc_r) * LD_W'(3 * PAGE_CAPACITY);

  assign q_ready        = (state_r == S_IDLE);
  assign res_valid      = (state_r == S_RES);
  assign res.value      = val_r;
  assign res.is_new     = rnew_r;
  assign res.table_full = rfull_r;

  always_comb begin
    state_nxt = state_r;  val_nxt = val_r;    b_nxt = b_r;      sp_nxt = sp_r;
    page_nxt = page_r;    tail_nxt = tail_r;  head_nxt = head_r; cur_nxt = cur_r;
    fill_nxt = fill_r;    cfill_nxt = cfill_r; sslot_nxt = sslot_r; mslot_nxt = mslot_r;
    slot_nxt = slot_r;    gath_nxt = gath_r;  grp_nxt = grp_r;
    rnew_nxt = rnew_r;    rfull_nxt = rfull_r; bc_nxt = bc_r;    hm_nxt = hm_r;
    smod_nxt = smod_r;    et_nxt = et_r;      n_nxt = n_r;      idx_nxt = idx_r;
    fc_nxt = fc_r;        oldp_nxt = oldp_r;  spg_nxt = spg_r;  mpg_nxt = mpg_r;
    ent_we = 1'b0;  spl_we = 1'b0;  fill_we = 1'b0; link_we = 1'b0;
    head_we = 1'b0; tail_we = 1'b0; fs_we = 1'b0;   lvs_en = 1'b0; lvc_en = 1'b0;
    ent_wpg = page_r; ent_wslot = '0; ent_wd = val_r; spl_wd = {mv, ent_q};
    fill_wa = page_r; fill_wd = '0; link_wa = page_r; link_wd = fs_q;
    head_wd = fs_q; tail_wd = fs_q; lvs_a = page_r; lvc_a = fs_q;
    case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          val_nxt   = q_value;
          state_nxt = S_HASH;
        end
      end
      S_HASH: begin
        b_nxt     = bkt_of(val_r, MOD_W'(bc_r), hm_r);
        gath_nxt  = 1'b0;
        state_nxt = S_HRD;
      end
      S_HRD: state_nxt = S_HEAD;
      S_HEAD: begin
        page_nxt  = head_q;
        head_nxt  = head_q;
        tail_nxt  = tail_q;
        slot_nxt  = '0;
        state_nxt = S_PGRD;
      end
      S_PGRD: state_nxt = S_PAGE;
      S_PAGE: begin
        fill_nxt  = fill_q;
        state_nxt = (fill_q == '0) ? S_EOP : S_ECMP;
      end
      S_ERD: state_nxt = S_ECMP;
      S_ECMP: begin
        if (!gath_r && ent_q == val_r) begin
          // already stored
          rnew_nxt  = 1'b0;
          rfull_nxt = 1'b0;
          state_nxt = S_RES;
        end else begin
          if (gath_r) begin
            spl_we = 1'b1;
            n_nxt  = n_r + 1'b1;
            if (mv) begin
              if (mslot_r == FILL_W'(PAGE_CAPACITY)) begin
                mpg_nxt   = mpg_r + 1'b1;
                mslot_nxt = FILL_W'(1);
              end else begin
                mslot_nxt = mslot_r + 1'b1;
              end
            end else begin
              if (sslot_r == FILL_W'(PAGE_CAPACITY)) begin
                spg_nxt   = spg_r + 1'b1;
                sslot_nxt = FILL_W'(1);
              end else begin
                sslot_nxt = sslot_r + 1'b1;
              end
            end
          end
          if (FILL_W'(slot_r) + FILL_W'(1) < fill_r) begin
            slot_nxt  = slot_r + 1'b1;
            state_nxt = S_ERD;
          end else begin
            state_nxt = S_EOP;
          end
        end
      end
      S_EOP: begin
        if (gath_r) begin
          oldp_nxt = oldp_r + 1'b1;
        end
        if (linkv_r[page_r]) begin
          page_nxt  = link_q;
          slot_nxt  = '0;
          state_nxt = S_PGRD;
        end else if (!gath_r) begin
          page_nxt  = tail_r;
          state_nxt = S_TWT;
        end else begin
          state_nxt = S_DEC;
        end
      end
      S_TWT: state_nxt = S_TAIL;
      S_TAIL: begin
        if (fill_q < FILL_W'(PAGE_CAPACITY)) begin
          ent_we    = 1'b1;
          ent_wslot = fill_q;
          fill_we   = 1'b1;
          fill_wd   = fill_q + 1'b1;
          et_nxt    = et_r + 1'b1;
          rnew_nxt  = 1'b1;
          rfull_nxt = 1'b0;
        end else if (fc_r == '0) begin
          rnew_nxt  = 1'b0;
          rfull_nxt = 1'b1;
        end else begin
          // link an overflow page from the free stack
          fc_nxt    = fc_r - 1'b1;
          link_we   = 1'b1;
          lvs_en    = 1'b1;
          lvc_en    = 1'b1;
          tail_we   = 1'b1;
          ent_we    = 1'b1;
          ent_wpg   = fs_q;
          fill_we   = 1'b1;
          fill_wa   = fs_q;
          fill_wd   = FILL_W'(1);
          et_nxt    = et_r + 1'b1;
          rnew_nxt  = 1'b1;
          rfull_nxt = 1'b0;
        end
        state_nxt = S_RES;
      end
      S_RES: begin
        if (res_ready) begin
          state_nxt = rnew_r ? S_CHK : S_IDLE;
        end
      end
      S_CHK: begin
        if (load_lhs > load_rhs && bc_r < BC_W'(MAX_BUCKETS)) begin
          gath_nxt  = 1'b1;
          b_nxt     = sp_r;
          smod_nxt  = (hm_r < nb_m) ? (hm_r << 1) : hm_r;
          n_nxt     = '0;
          oldp_nxt  = '0;
          spg_nxt   = PC_W'(1);
          mpg_nxt   = PC_W'(1);
          sslot_nxt = '0;
          mslot_nxt = '0;
          state_nxt = S_HRD;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_DEC: begin
        if ((PC_W + 1)'(spg_r) + (PC_W + 1)'(mpg_r) >
            (PC_W + 1)'(oldp_r) + (PC_W + 1)'(fc_r)) begin
          state_nxt = S_IDLE;
        end else begin
          page_nxt  = head_r;
          state_nxt = S_FWT;
        end
      end
      S_FWT: state_nxt = S_FPUSH;
      S_FPUSH: begin
        fs_we  = 1'b1;
        fc_nxt = fc_r + 1'b1;
        if (linkv_r[page_r]) begin
          page_nxt  = link_q;
          state_nxt = S_FWT;
        end else begin
          grp_nxt   = 1'b0;
          state_nxt = S_BW;
        end
      end
      S_BW: state_nxt = S_BT;
      S_BT: begin
        fc_nxt    = fc_r - 1'b1;
        head_we   = 1'b1;
        tail_we   = 1'b1;
        lvc_en    = 1'b1;
        fill_we   = 1'b1;
        fill_wa   = fs_q;
        fill_wd   = '0;
        cur_nxt   = fs_q;
        cfill_nxt = '0;
        idx_nxt   = '0;
        state_nxt = S_SRD;
      end
      S_SRD: begin
        if (idx_r == n_r) begin
          if (!grp_r) begin
            grp_nxt   = 1'b1;
            b_nxt     = bc_r[BK_W-1:0];
            state_nxt = S_BW;
          end else begin
            state_nxt = S_FIN;
          end
        end else begin
          state_nxt = S_SCHK;
        end
      end
      S_SCHK: begin
        if (spl_q[DW] == grp_r) begin
          ent_we = 1'b1;
          ent_wd = spl_q[DW-1:0];
          if (cfill_r == FILL_W'(PAGE_CAPACITY)) begin
            fc_nxt    = fc_r - 1'b1;
            link_we   = 1'b1;
            link_wa   = cur_r;
            lvs_en    = 1'b1;
            lvs_a     = cur_r;
            lvc_en    = 1'b1;
            tail_we   = 1'b1;
            ent_wpg   = fs_q;
            fill_we   = 1'b1;
            fill_wa   = fs_q;
            fill_wd   = FILL_W'(1);
            cur_nxt   = fs_q;
            cfill_nxt = FILL_W'(1);
          end else begin
            ent_wpg   = cur_r;
            ent_wslot = cfill_r;
            fill_we   = 1'b1;
            fill_wa   = cur_r;
            fill_wd   = cfill_r + 1'b1;
            cfill_nxt = cfill_r + 1'b1;
          end
        end
        idx_nxt   = idx_r + 1'b1;
        state_nxt = S_SRD;
      end
      S_FIN: begin
        bc_nxt    = bc_r + 1'b1;
        hm_nxt    = smod_r;
        sp_nxt    = (MOD_W'(sp_r) + MOD_W'(1) == (smod_r >> 1)) ? '0 : sp_r + 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      bc_r    <= BC_W'(2);
      hm_r    <= MOD_W'(2);
      sp_r    <= '0;
      et_r    <= '0;
      fc_r    <= FC_W'(MAX_PAGES - 2);
    end else begin
      state_r <= state_nxt;
      bc_r    <= bc_nxt;
      hm_r    <= hm_nxt;
      sp_r    <= sp_nxt;
      et_r    <= et_nxt;
      fc_r    <= fc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;    b_r <= b_nxt;        page_r <= page_nxt;  tail_r <= tail_nxt;
    head_r <= head_nxt;  cur_r <= cur_nxt;    fill_r <= fill_nxt;  cfill_r <= cfill_nxt;
    sslot_r <= sslot_nxt; mslot_r <= mslot_nxt; slot_r <= slot_nxt; gath_r <= gath_nxt;
    grp_r <= grp_nxt;    rnew_r <= rnew_nxt;  rfull_r <= rfull_nxt; smod_r <= smod_nxt;
    n_r <= n_nxt;        idx_r <= idx_nxt;    oldp_r <= oldp_nxt;  spg_r <= spg_nxt;
    mpg_r <= mpg_nxt;
  end

  // valid bits: an entry never written reads as its reset value
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_vld_r <= '0;
      linkv_r    <= '0;
      head_vld_r <= '0;
      tail_vld_r <= '0;
    end else begin
      if (fill_we) fill_vld_r[fill_wa] <= 1'b1;
      if (head_we) head_vld_r[b_r] <= 1'b1;
      if (tail_we) tail_vld_r[b_r] <= 1'b1;
      if (lvc_en)  linkv_r[lvc_a] <= 1'b0;
      if (lvs_en)  linkv_r[lvs_a] <= 1'b1;
    end
  end

  // low-water mark of the free stack: slots from the mark up to the count were
  // pushed since, slots below it still hold their reset contents
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fcmin_r <= FC_W'(MAX_PAGES - 2);
    end else if (fc_nxt < fcmin_r) begin
      fcmin_r <= fc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ent_we) ent_mem[ent_wa] <= ent_wd;
    ent_q <= ent_mem[ent_ra];
  end

  always_ff @(posedge clk) begin
    if (spl_we) spl_mem[n_r[SA_W-1:0]] <= spl_wd;
    spl_q <= spl_mem[idx_r[SA_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (fill_we) fill_mem[fill_wa] <= fill_wd;
    fill_q <= fill_vld_r[page_r] ? fill_mem[page_r] : '0;
  end

  always_ff @(posedge clk) begin
    if (link_we) link_mem[link_wa] <= link_wd;
    link_q <= link_mem[page_r];
  end

  always_ff @(posedge clk) begin
    if (head_we) head_mem[b_r] <= head_wd;
    head_q <= head_vld_r[b_r] ? head_mem[b_r] :
              ((b_r < BK_W'(2)) ? PG_W'(b_r) : '0);
  end

  always_ff @(posedge clk) begin
    if (tail_we) tail_mem[b_r] <= tail_wd;
    tail_q <= tail_vld_r[b_r] ? tail_mem[b_r] :
              ((b_r < BK_W'(2)) ? PG_W'(b_r) : '0);
  end

  always_ff @(posedge clk) begin
    if (fs_we) fs_mem[fc_r[PG_W-1:0]] <= page_r;
    fs_q <= (FC_W'(fs_ra) >= fcmin_r) ? fs_mem[fs_ra] :
            (PG_W'(MAX_PAGES - 1) - fs_ra);
  end

`ifndef SYNTH
  a_pages_owned: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> (FC_W + 1)'(fc_r) + (FC_W + 1)'(bc_r) <= (FC_W + 1)'(MAX_PAGES))
    else $error("free pages and buckets exceed the page pool");
  a_modulus: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> (hm_r >= MOD_W'(bc_r)) &&
                            ((MOD_W + 1)'(hm_r) < (MOD_W + 1)'(bc_r) * 2))
    else $error("hash modulus out of step with bucket count");
  a_split_ptr: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> MOD_W'(sp_r) < (hm_r >> 1))
    else $error("split pointer beyond half the modulus");
  a_res_flags: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> !(res.is_new && res.table_full))
    else $error("item both inserted and rejected");
  a_split_after_insert: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RES && res_ready && !rnew_r) |=> (state_r == S_IDLE))
    else $error("split started without an insert");
`endif

endmodule
`default_nettype wire

@@ design/linear_hash_dedup_filter_core.sv @@
// top level of the linear hash duplicate filter: queue, engine and output register
`default_nettype none
// Duplicate filter over a linear-hashing table. Every item offered on in_value comes
// back once on out_value, in order, with out_is_new set when the value was absent and
// has now been stored, or out_table_full set when a new page was needed and the page
// pool was empty. Items enter a two-deep queue, so the input keeps accepting while the
// engine works and while a finished result waits in the output register. The engine
// handles one item at a time and its single-port memories set the pace: it scans the
// bucket's chain page by page and entry by entry. An insert that pushes the load above
// three quarters of the table also splits one bucket before the next item starts,
// unless all buckets are in use or the two new chains would not fit: it gathers the
// bucket's entries page by page, releases its pages to the free stack and rebuilds
// both new chains, each scanning every gathered entry. Valid bits on the page and
// bucket tables and a low-water mark on the free-page stack stand in for their reset
// state, so the block is ready right after reset with no clearing pass.
module linear_hash_dedup_filter_core #(
  parameter int unsigned PAGE_CAPACITY = 30,
  parameter int unsigned MAX_BUCKETS   = 64,
  parameter int unsigned MAX_PAGES     = 128
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic signed [lhd_pkg::DATA_W-1:0]   in_value,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic signed [lhd_pkg::DATA_W-1:0]        out_value,
  output logic                                     out_is_new,
  output logic                                     out_table_full
);

  // queue to engine
  logic                              q_valid;
  logic                              q_ready;
  logic signed [lhd_pkg::DATA_W-1:0] q_value;

  // engine to output register
  logic              res_valid;
  logic              res_ready;
  lhd_pkg::lhd_res_t res;

  // output register
  logic              ov_r, ov_nxt;
  lhd_pkg::lhd_res_t ob_r, ob_nxt;

  lhd_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_value (in_value),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_value  (q_value)
  );

  lhd_engine #(
    .PAGE_CAPACITY (PAGE_CAPACITY),
    .MAX_BUCKETS   (MAX_BUCKETS),
    .MAX_PAGES     (MAX_PAGES)
  ) u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_value   (q_value),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  // the register takes a new result whenever it is empty or being drained
  assign res_ready = !ov_r || out_ready;

  always_comb begin
    ov_nxt = ov_r;
    ob_nxt = ob_r;
    if (res_valid && res_ready) begin
      ov_nxt = 1'b1;
      ob_nxt = res;
    end else if (out_ready) begin
      ov_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else begin
      ov_r <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ob_r <= ob_nxt;
  end

  assign out_valid      = ov_r;
  assign out_value      = ob_r.value;
  assign out_is_new     = ob_r.is_new;
  assign out_table_full = ob_r.table_full;

endmodule
`default_nettype wire

@@ verif/tb_top.sv @@
// testbench for the linear hash duplicate filter: predictor, scoreboard and drivers
`default_nettype none

class lhd_scoreboard;
  localparam int unsigned CAP   = 30;
  localparam int unsigned NBKT  = 64;
  localparam int unsigned NPAGE = 128;
  localparam int unsigned DEPTH = NPAGE * CAP;

  typedef struct {
    logic [31:0] value;
    bit          is_new;
    bit          table_full;
  } lhd_result_t;

  // table image
  logic [31:0] entries[DEPTH];
  int unsigned fill_cnt[NPAGE];
  int unsigned next_page[NPAGE];
  bit          next_ok[NPAGE];
  int unsigned head[NBKT];
  int unsigned tail[NBKT];
  int unsigned free_stack[NPAGE];
  int unsigned free_cnt;
  int unsigned bkt_cnt;
  int unsigned modulus;
  int unsigned split_at;
  int unsigned stored;
  logic [31:0] gather[DEPTH];
  bit          gather_moves[DEPTH];

  lhd_result_t awaited[$];
  logic [31:0] offered[$];
  int unsigned mismatches;
  int unsigned fulls_seen;
  int unsigned new_seen;

  function new();
    int unsigned i;
    for (i = 0; i < NPAGE; i++) begin
      fill_cnt[i] = 0;
      next_page[i] = 0;
      next_ok[i] = 0;
    end
    for (i = 0; i < NBKT; i++) begin
      head[i] = 0;
      tail[i] = 0;
    end
    head[1] = 1;
    tail[1] = 1;
    free_cnt = 0;
    for (i = NPAGE; i > 2; i--) begin
      free_stack[free_cnt] = i - 1;
      free_cnt++;
    end
    bkt_cnt = 2;
    modulus = 2;
    split_at = 0;
    stored = 0;
    mismatches = 0;
    fulls_seen = 0;
    new_seen = 0;
  endfunction

  function int unsigned bucket_for(logic [31:0] v, int unsigned cnt, int unsigned md);
    int unsigned idx;
    idx = v & (md - 1);
    if (idx >= cnt) idx -= (md >> 1);
    if (idx >= cnt || idx >= NBKT) idx = 0;
    return idx;
  endfunction

  function bit grab_page(output int unsigned pg);
    pg = 0;
    if (free_cnt == 0) return 0;
    free_cnt--;
    pg = free_stack[free_cnt] % NPAGE;
    fill_cnt[pg] = 0;
    next_ok[pg] = 0;
    return 1;
  endfunction

  function bit chain_append(int unsigned b, logic [31:0] v);
    int unsigned t;
    int unsigned n;
    t = tail[b] % NPAGE;
    if (fill_cnt[t] >= CAP) begin
      if (!grab_page(n)) return 0;
      next_page[t] = n;
      next_ok[t] = 1;
      tail[b] = n;
      t = n;
    end
    entries[t * CAP + fill_cnt[t]] = v;
    fill_cnt[t]++;
    return 1;
  endfunction

  function int unsigned pages_needed(int unsigned n);
    return (n == 0) ? 1 : (n + CAP - 1) / CAP;
  endfunction

  function void rebuild(int unsigned b, int unsigned n, bit moves);
    int unsigned pg;
    int unsigned i;
    bit ok;
    ok = grab_page(pg);
    head[b] = pg;
    tail[b] = pg;
    for (i = 0; i < n; i++)
      if (gather_moves[i] == moves) ok = chain_append(b, gather[i]);
  endfunction

  function void split_one();
    int unsigned s, nb, md, n, old_pages, moved, i, pg, steps, nxt;
    bit more;
    s = split_at % NBKT;
    nb = bkt_cnt + 1;
    md = modulus;
    n = 0;
    old_pages = 0;
    moved = 0;
    if (bkt_cnt >= NBKT) return;
    if (md < nb) md = md << 1;
    pg = head[s] % NPAGE;
    for (steps = 0; steps < NPAGE; steps++) begin
      for (i = 0; i < fill_cnt[pg] && i < CAP; i++) begin
        gather[n] = entries[pg * CAP + i];
        gather_moves[n] = (bucket_for(gather[n], nb, md) == bkt_cnt);
        if (gather_moves[n]) moved++;
        n++;
      end
      old_pages++;
      if (!next_ok[pg]) break;
      pg = next_page[pg] % NPAGE;
    end
    // skip the split when the two new chains would not fit
    if (pages_needed(n - moved) + pages_needed(moved) > old_pages + free_cnt) return;
    pg = head[s] % NPAGE;
    for (steps = 0; steps < NPAGE; steps++) begin
      more = next_ok[pg];
      nxt = next_page[pg] % NPAGE;
      next_ok[pg] = 0;
      fill_cnt[pg] = 0;
      if (free_cnt < NPAGE) begin
        free_stack[free_cnt] = pg;
        free_cnt++;
      end
      if (!more) break;
      pg = nxt;
    end
    rebuild(s, n, 0);
    rebuild(bkt_cnt, n, 1);
    bkt_cnt = nb;
    modulus = md;
    split_at++;
    if (split_at == (modulus >> 1)) split_at = 0;
  endfunction

  function lhd_result_t insert_value(logic [31:0] v);
    lhd_result_t r;
    int unsigned b, pg, i, steps;
    r.value = v;
    r.is_new = 0;
    r.table_full = 0;
    b = bucket_for(v, bkt_cnt, modulus);
    pg = head[b] % NPAGE;
    for (steps = 0; steps < NPAGE; steps++) begin
      for (i = 0; i < fill_cnt[pg] && i < CAP; i++)
        if (entries[pg * CAP + i] == v) return r;
      if (!next_ok[pg]) break;
      pg = next_page[pg] % NPAGE;
    end
    if (!chain_append(b, v)) begin
      r.table_full = 1;
      return r;
    end
    stored++;
    r.is_new = 1;
    if (4 * stored > 3 * bkt_cnt * CAP) split_one();
    return r;
  endfunction

  // an item was accepted on the input
  function void note_input(logic [31:0] v);
    lhd_result_t r;
    r = insert_value(v);
    if (r.table_full) fulls_seen++;
    if (r.is_new) new_seen++;
    awaited = {awaited, r};
    offered = {offered, v};
  endfunction

  // a result item was accepted on the output
  function void check_result(logic [31:0] v, logic nw, logic full);
    lhd_result_t e;
    if (awaited.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected result: value %h new %b full %b", v, nw, full);
      return;
    end
    e = awaited.pop_front();
    if (v !== e.value || nw !== e.is_new || full !== e.table_full) begin
      mismatches++;
      if (mismatches <= 10)
        $display("result mismatch: expected value %h new %b full %b, got %h %b %b",
                 e.value, e.is_new, e.table_full, v, nw, full);
    end
  endfunction

  function int unsigned pending();
    return awaited.size();
  endfunction
endclass

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned IDLE_LIMIT = 20000;
  localparam int unsigned HOLD_LEN   = 400;

  logic                              clk;
  logic                              rst_n;
  logic                              in_valid;
  logic                              in_ready;
  logic signed [lhd_pkg::DATA_W-1:0] in_value;
  logic                              out_valid;
  logic                              out_ready;
  logic signed [lhd_pkg::DATA_W-1:0] out_value;
  logic                              out_is_new;
  logic                              out_table_full;

  lhd_scoreboard dedup_sb;
  bit            hold_req;
  bit            calm_rx;
  int unsigned   idle_cycles = 0;

  linear_hash_dedup_filter_core dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_value       (in_value),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_value      (out_value),
    .out_is_new     (out_is_new),
    .out_table_full (out_table_full)
  );

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  // offer one item and hold it until the block takes it
  task automatic offer_value(logic [31:0] v);
    in_valid <= 1'b1;
    in_value <= v;
    do @(posedge clk); while (!in_ready);
    dedup_sb.note_input(v);
  endtask

  task automatic sender_gap(int unsigned n);
    if (n == 0) return;
    in_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // stop offering until every awaited result is back
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (dedup_sb.pending() != 0);
  endtask

  // mostly fresh values, some repeats of earlier ones
  function automatic logic [31:0] pick_value(int unsigned repeat_pct);
    int unsigned n;
    n = dedup_sb.offered.size();
    if (n != 0 && $urandom_range(99) < repeat_pct)
      return dedup_sb.offered[$urandom_range(n - 1)];
    return $urandom();
  endfunction

  // burst of items, usually followed by a random gap
  task automatic send_burst(int unsigned repeat_pct, int unsigned max_gap);
    int unsigned len;
    int unsigned k;
    len = $urandom_range(1, 16);
    for (k = 0; k < len; k++) offer_value(pick_value(repeat_pct));
    if ($urandom_range(3) != 0) sender_gap($urandom_range(max_gap));
  endtask

  // receiver: one of four stall patterns, drawn at random, plus a long hold on request
  initial begin
    int unsigned cyc;
    int unsigned mode;
    int unsigned held;
    out_ready = 1'b0;
    cyc = 0;
    mode = 0;
    forever begin
      @(posedge clk);
      cyc++;
      if (cyc % 64 == 0) mode = $urandom_range(3);
      if (hold_req) begin
        out_ready <= 1'b0;
        for (held = 1; held < HOLD_LEN; held++) @(posedge clk);
        hold_req = 0;
      end else if (calm_rx || mode == 0) begin
        out_ready <= 1'b1;
      end else if (mode == 1) begin
        out_ready <= ($urandom_range(9) < 7);
      end else if (mode == 2) begin
        out_ready <= (cyc % 8 >= 3);
      end else begin
        out_ready <= ($urandom_range(9) < 2);
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      dedup_sb.check_result(out_value, out_is_new, out_table_full);
  end

  // watchdog: cycles with work outstanding but nothing moving
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) ||
        (dedup_sb.pending() == 0 && !in_valid)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  initial begin
    logic [31:0] corner[$];
    int unsigned k;
    dedup_sb = new();
    hold_req = 0;
    calm_rx = 0;
    in_valid = 1'b0;
    in_value = '0;
    rst_n = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: extremes, alternating bits, and duplicates of every second one
    corner = '{32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF, 32'h7FFF_FFFF,
               32'h8000_0000, 32'h5555_5555, 32'hAAAA_AAAA, 32'h0000_0002,
               32'hFFFF_FFFE, 32'h0001_0000};
    foreach (corner[i]) offer_value(corner[i]);
    sender_gap(3);
    foreach (corner[i]) if (i % 2 == 0) offer_value(corner[i]);
    offer_value(32'h8000_0000);
    offer_value(32'h8000_0000);
    drain_results();

    // long receiver hold while the sender keeps offering
    hold_req = 1;
    for (k = 0; k < 20; k++) offer_value(pick_value(20));
    drain_results();

    // random part: bursts with gaps, about one in five a repeat, with a drain and a receiver hold midway
    for (k = 0; k < 60; k++) begin
      send_burst(20, 12);
      if (k == 30) begin
        drain_results();
        hold_req = 1;
      end
    end

    // steady insert stream with a ready receiver to drive the table through splits
    calm_rx = 1;
    k = 0;
    while (dedup_sb.fulls_seen < 40 && k < 230) begin
      offer_value(pick_value(10));
      if ($urandom_range(15) == 0) sender_gap($urandom_range(4));
      k++;
    end
    calm_rx = 0;
    for (k = 0; k < 8; k++) send_burst(50, 6);

    drain_results();
    repeat (600) @(posedge clk);
    if (dedup_sb.mismatches == 0 && dedup_sb.pending() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end
endmodule

`default_nettype wire

@@ filelist.f @@
design/lhd_pkg.sv
design/lhd_front.sv
design/lhd_engine.sv
design/linear_hash_dedup_filter_core.sv
verif/tb_top.sv
